// File: hw/rtl/pvmd_pkg.sv
// pvmd_pkg: types and constants shared by the planar video memory datapath
// no dependencies; used by the interfaces, pvmd_alu and the top level
package pvmd_pkg;

  localparam int unsigned NumPlanes   = 4;
  localparam int unsigned ByteWidth   = 8;
  localparam int unsigned AddrWidth   = 16;
  localparam int unsigned CfgIdxWidth = 8;
  localparam int unsigned CfgDatWidth = 8;
  localparam int unsigned WordWidth   = NumPlanes * ByteWidth;

  typedef logic [ByteWidth-1:0]                 byte_t;
  typedef logic [NumPlanes-1:0][ByteWidth-1:0]  word_t;

  // configuration register indexes
  typedef enum logic [CfgIdxWidth-1:0] {
    REG_SET_RESET     = 8'd0,
    REG_COLOR_COMPARE = 8'd1,
    REG_DATA_ROTATE   = 8'd2,
    REG_GRAPHICS_MODE = 8'd3,
    REG_BIT_MASK      = 8'd4,
    REG_MAP_MASK      = 8'd5,
    REG_READ_MAP_SEL  = 8'd6,
    REG_GRAPHICS_EN   = 8'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    WMODE_ROTATE = 2'd0,
    WMODE_LATCH  = 2'd1,
    WMODE_EXPAND = 2'd2,
    WMODE_MASKED = 2'd3
  } wmode_e;

  typedef enum logic [1:0] {
    LOP_NONE = 2'd0,
    LOP_AND  = 2'd1,
    LOP_OR   = 2'd2,
    LOP_XOR  = 2'd3
  } lop_e;

  typedef struct packed {
    logic [7:0] set_reset_ctrl;
    logic [7:0] color_compare_ctrl;
    logic [4:0] data_rotate;
    logic [3:0] graphics_mode;
    logic [7:0] bit_mask;
    logic [3:0] map_mask;
    logic [1:0] read_map_select;
    logic       graphics_enable;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    set_reset_ctrl:     8'h00,
    color_compare_ctrl: 8'h00,
    data_rotate:        5'd0,
    graphics_mode:      4'd0,
    bit_mask:           8'hff,
    map_mask:           4'hf,
    read_map_select:    2'd0,
    graphics_enable:    1'b0
  };

endpackage

// File: hw/rtl/pvmd_if.sv
// pvmd_if: valid/ready channel interfaces for requests, responses and config
// depends on pvmd_pkg for field widths
interface pvmd_req_if;
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic [pvmd_pkg::AddrWidth-1:0]    addr;
  logic [pvmd_pkg::ByteWidth-1:0]    wdata;

  modport source (output valid, output req_type, output addr, output wdata, input ready);
  modport sink   (input valid, input req_type, input addr, input wdata, output ready);
endinterface

interface pvmd_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [pvmd_pkg::ByteWidth-1:0] rdata;

  modport source (output valid, output rdata, input ready);
  modport sink   (input valid, input rdata, output ready);
endinterface

interface pvmd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [pvmd_pkg::CfgIdxWidth-1:0] index;
  logic [pvmd_pkg::CfgDatWidth-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/pvmd_ram.sv
// pvmd_ram: generic single-port synchronous ram with registered read
// no dependencies
module pvmd_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/pvmd_alu.sv
// pvmd_alu: write-mode data build, plane merge, colour compare and read select
// depends on pvmd_pkg (cfg_t, word_t, write mode and logic op codes)
module pvmd_alu (
  input  pvmd_pkg::cfg_t  cfg_i,
  input  logic            is_write_i,
  input  pvmd_pkg::byte_t wdata_i,
  input  pvmd_pkg::word_t mem_word_i,
  input  pvmd_pkg::word_t latches_i,
  output pvmd_pkg::word_t new_word_o,
  output pvmd_pkg::byte_t result_o
);

  pvmd_pkg::wmode_e wmode;
  pvmd_pkg::lop_e   lop;
  logic [15:0]      rot_wide;
  pvmd_pkg::byte_t  rot;
  pvmd_pkg::byte_t  bmask;
  pvmd_pkg::byte_t  mmask;
  logic [3:0]       srval, sren, color, care;
  pvmd_pkg::word_t  gfx_word;
  pvmd_pkg::byte_t  cmp_mask;

  assign wmode    = pvmd_pkg::wmode_e'(cfg_i.graphics_mode[1:0]);
  assign lop      = pvmd_pkg::lop_e'(cfg_i.data_rotate[4:3]);
  assign rot_wide = {wdata_i, wdata_i} >> cfg_i.data_rotate[2:0];
  assign rot      = rot_wide[7:0];
  assign bmask    = cfg_i.bit_mask;
  assign mmask    = rot & bmask;
  assign srval    = cfg_i.set_reset_ctrl[3:0];
  assign sren     = cfg_i.set_reset_ctrl[7:4];
  assign color    = cfg_i.color_compare_ctrl[3:0];
  assign care     = cfg_i.color_compare_ctrl[7:4];

  // per-plane data for a graphics write
  always_comb begin
    pvmd_pkg::byte_t d, lat;
    for (int p = 0; p < pvmd_pkg::NumPlanes; p++) begin
      lat = latches_i[p];
      case (wmode)
        pvmd_pkg::WMODE_LATCH: begin
          d = lat;
        end
        pvmd_pkg::WMODE_MASKED: begin
          d = ({8{srval[p]}} & mmask) | (lat & ~mmask);
        end
        default: begin
          if (wmode == pvmd_pkg::WMODE_ROTATE) begin
            d = sren[p] ? {8{srval[p]}} : rot;
          end else begin
            d = {8{wdata_i[p]}};
          end
          case (lop)
            pvmd_pkg::LOP_AND: d = d & lat;
            pvmd_pkg::LOP_OR:  d = d | lat;
            pvmd_pkg::LOP_XOR: d = d ^ lat;
            default:           d = d;
          endcase
          d = (d & bmask) | (lat & ~bmask);
        end
      endcase
      gfx_word[p] = cfg_i.map_mask[p] ? d : mem_word_i[p];
    end
  end

  // colour compare over the freshly read word, one bit per pixel
  always_comb begin
    logic [3:0] c;
    for (int i = 0; i < pvmd_pkg::ByteWidth; i++) begin
      for (int p = 0; p < pvmd_pkg::NumPlanes; p++) begin
        c[p] = mem_word_i[p][i];
      end
      cmp_mask[i] = (((c ^ color) & care) == 4'd0);
    end
  end

  always_comb begin
    new_word_o = mem_word_i;
    result_o   = '0;
    if (!cfg_i.graphics_enable) begin
      if (is_write_i) begin
        new_word_o[0] = wdata_i;
      end else begin
        result_o = mem_word_i[0];
      end
    end else if (is_write_i) begin
      new_word_o = gfx_word;
    end else if (cfg_i.graphics_mode[3]) begin
      result_o = cmp_mask;
    end else begin
      result_o = mem_word_i[cfg_i.read_map_select];
    end
  end

endmodule

// File: hw/rtl/planar_video_memory_datapath_core.sv
// planar_video_memory_datapath_core: cpu access path to four-plane video memory
// depends on pvmd_pkg, the pvmd interfaces, pvmd_ram and pvmd_alu
//
//  channel  | direction | payload                 | transaction when
//  ---------+-----------+-------------------------+--------------------------
//  req_i    | in        | req_type, addr, wdata   | req_i.valid & req_i.ready
//  rsp_o    | out       | rdata                   | rsp_o.valid & rsp_o.ready
//  cfg_i    | in        | index, data             | cfg_i.valid & cfg_i.ready
//
// the plane word of a request is read from the single-port
// ram in the cycle the request is taken, then modified and written back (or
// returned) in the next one; no new request is taken while that access runs
// rsp_o holds one result register; a new request is taken once it is empty or
// draining in the same cycle, so a stalled response holds the request side off
// reset clears control state, the config registers and the read latches;
// the plane memory itself is undefined until written and is not cleared
// cfg_i is always ready
module planar_video_memory_datapath_core #(
  parameter int unsigned PLANE_ADDR_BITS = 16,
  parameter int unsigned TEXT_ADDR_BITS  = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pvmd_req_if.sink    req_i,
  pvmd_rsp_if.source  rsp_o,
  pvmd_cfg_if.sink    cfg_i
);

  localparam int unsigned Depth    = 2 ** PLANE_ADDR_BITS;
  localparam int unsigned TextKeep = (TEXT_ADDR_BITS < PLANE_ADDR_BITS) ?
                                     TEXT_ADDR_BITS : PLANE_ADDR_BITS;
  localparam logic [PLANE_ADDR_BITS-1:0] TextAddrMask =
    PLANE_ADDR_BITS'((32'd1 << TextKeep) - 32'd1);

  typedef enum logic {
    StIdle,
    StAccess
  } state_e;

  state_e state_q;

  // config registers
  pvmd_pkg::cfg_t cfg_q;

  // request held for the access cycle
  logic                       is_write_q;
  logic [PLANE_ADDR_BITS-1:0] addr_q;
  pvmd_pkg::byte_t            wdata_q;

  // read latches, one byte per plane
  pvmd_pkg::word_t latches_q;

  // response register
  logic            rsp_valid_q;
  pvmd_pkg::byte_t rdata_q;

  logic                       accept;
  logic                       in_access;
  logic [PLANE_ADDR_BITS-1:0] req_addr;
  logic [PLANE_ADDR_BITS-1:0] ram_addr;
  logic                       ram_en;
  logic                       ram_we;
  pvmd_pkg::word_t            ram_rdata;
  pvmd_pkg::word_t            new_word;
  pvmd_pkg::byte_t            result;

  // --- config write port ---
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= pvmd_pkg::CfgReset;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        pvmd_pkg::REG_SET_RESET:     cfg_q.set_reset_ctrl     <= cfg_i.data;
        pvmd_pkg::REG_COLOR_COMPARE: cfg_q.color_compare_ctrl <= cfg_i.data;
        pvmd_pkg::REG_DATA_ROTATE:   cfg_q.data_rotate        <= cfg_i.data[4:0];
        pvmd_pkg::REG_GRAPHICS_MODE: cfg_q.graphics_mode      <= cfg_i.data[3:0];
        pvmd_pkg::REG_BIT_MASK:      cfg_q.bit_mask           <= cfg_i.data;
        pvmd_pkg::REG_MAP_MASK:      cfg_q.map_mask           <= cfg_i.data[3:0];
        pvmd_pkg::REG_READ_MAP_SEL:  cfg_q.read_map_select    <= cfg_i.data[1:0];
        pvmd_pkg::REG_GRAPHICS_EN:   cfg_q.graphics_enable    <= cfg_i.data[0];
        default: ; // indexes beyond the register list are dropped
      endcase
    end
  end

  // --- request side ---
  assign in_access   = (state_q == StAccess);
  assign req_i.ready = (state_q == StIdle) && (!rsp_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  // text addressing stays on a narrower window of plane 0
  assign req_addr = cfg_q.graphics_enable ? req_i.addr[PLANE_ADDR_BITS-1:0] :
                    (req_i.addr[PLANE_ADDR_BITS-1:0] & TextAddrMask);

  // read on the accepting edge, write back at the end of the access cycle
  assign ram_addr = in_access ? addr_q : req_addr;
  assign ram_we   = in_access && is_write_q;
  assign ram_en   = accept || ram_we;

  pvmd_ram #(
    .Width (pvmd_pkg::WordWidth),
    .Depth (Depth)
  ) u_plane_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (new_word),
    .rdata_o (ram_rdata)
  );

  pvmd_alu u_alu (
    .cfg_i      (cfg_q),
    .is_write_i (is_write_q),
    .wdata_i    (wdata_q),
    .mem_word_i (ram_rdata),
    .latches_i  (latches_q),
    .new_word_o (new_word),
    .result_o   (result)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      is_write_q <= req_i.req_type;
      addr_q     <= req_addr;
      wdata_q    <= req_i.wdata;
    end
  end

  // graphics reads reload all four latches from the word just read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latches_q <= '0;
    end else if (in_access && cfg_q.graphics_enable && !is_write_q) begin
      latches_q <= ram_rdata;
    end
  end

  // --- sequencer and response register ---
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rsp_valid_q <= 1'b0;
      rdata_q     <= '0;
    end else begin
      if (rsp_valid_q && rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        StIdle: begin
          if (accept) begin
            state_q <= StAccess;
          end
        end
        StAccess: begin
          // response register is known empty here
          rsp_valid_q <= 1'b1;
          rdata_q     <= result;
          state_q     <= StIdle;
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.rdata = rdata_q;

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// tb_top: self-checking bench for planar_video_memory_datapath_core
// keeps its own plane memory, read latches and register copy to predict every rdata
// depends on pvmd_pkg, the pvmd interfaces and the core rtl
module tb_top;
  import pvmd_pkg::*;

  localparam int unsigned HalfPeriod = 5;
  localparam int unsigned LimitNs    = 3_000_000;
  localparam int unsigned ItemTarget = 1000;
  localparam int unsigned DrainPause = 4;
  localparam int unsigned MaxShown   = 40;

  localparam logic [AddrWidth-1:0]   TextMask     = 16'h7fff;
  localparam logic [CfgIdxWidth-1:0] UnusedRegIdx = 8'd15;
  localparam byte_t                  ReadCompare  = 8'h08;

  localparam logic ReqRead  = 1'b0;
  localparam logic ReqWrite = 1'b1;

  // kinds of register setting used between random phases
  localparam int CfgRandom  = 0;
  localparam int CfgAllZero = 1;
  localparam int CfgAllOnes = 2;

  typedef struct packed {
    logic                 req_type;
    logic [AddrWidth-1:0] addr;
    byte_t                wdata;
  } mem_req_t;

  logic clk;
  logic rst_n = 1'b0;

  pvmd_req_if req_if ();
  pvmd_rsp_if rsp_if ();
  pvmd_cfg_if cfg_if ();

  // bench-side drive registers, all known from time zero
  logic                   drv_valid = 1'b0;
  logic                   drv_type  = 1'b0;
  logic [AddrWidth-1:0]   drv_addr  = '0;
  byte_t                  drv_wdata = '0;
  logic                   mon_ready = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_index = '0;
  logic [CfgDatWidth-1:0] cfg_data  = '0;

  assign req_if.valid    = drv_valid;
  assign req_if.req_type = drv_type;
  assign req_if.addr     = drv_addr;
  assign req_if.wdata    = drv_wdata;
  assign rsp_if.ready    = mon_ready;
  assign cfg_if.valid    = cfg_valid;
  assign cfg_if.index    = cfg_index;
  assign cfg_if.data     = cfg_data;

  planar_video_memory_datapath_core u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // predictor state: registers, plane words and the four read latches
  cfg_t  cfg_shadow = CfgReset;
  word_t plane_ram [int];
  byte_t latch_q [NumPlanes] = '{default: '0};

  mem_req_t req_backlog [$];   // transactions waiting for the driver
  byte_t    rdata_due   [$];   // predicted rdata, oldest first

  // planes written so far per memory word, so no read touches undefined bytes
  logic [NumPlanes-1:0] plane_fill [int];
  logic [AddrWidth-1:0] addr_pool [$];

  int unsigned err_count    = 0;
  int unsigned items_queued = 0;
  int unsigned rsp_count    = 0;
  int unsigned cyc          = 0;

  initial begin
    clk = 1'b0;
    forever #HalfPeriod clk = ~clk;
  end

  always @(negedge clk) cyc <= cyc + 1;

  // idle on about 16 calls in a hundred, except for a quiet stretch in every window
  function automatic bit take_break();
    return ((cyc % 2500) < 1900) && ($urandom_range(99) < 16);
  endfunction

  task automatic note_mismatch(input string msg);
    err_count++;
    if (err_count <= MaxShown) $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  function automatic byte_t rot_right(input byte_t v, input logic [2:0] r);
    logic [15:0] dbl;
    dbl = {v, v} >> r;
    return dbl[7:0];
  endfunction

  function automatic byte_t apply_lop(input byte_t d, input byte_t l, input lop_e op);
    case (op)
      LOP_AND: return d & l;
      LOP_OR:  return d | l;
      LOP_XOR: return d ^ l;
      default: return d;
    endcase
  endfunction

  // one memory access on the predictor; queues the rdata it should give
  task automatic model_access(input mem_req_t rq);
    logic [AddrWidth-1:0] a;
    word_t                word;
    byte_t                res;
    byte_t                rot;
    byte_t                d;
    byte_t                m;
    wmode_e               mode;
    logic [3:0]           srval;
    logic [3:0]           sren;
    logic [3:0]           colour;
    logic [3:0]           care;
    logic [NumPlanes-1:0] pix;
    res = '0;
    if (!cfg_shadow.graphics_enable) begin
      // text addressing: plane 0 only, latches untouched
      a    = rq.addr & TextMask;
      word = plane_ram.exists(a) ? plane_ram[a] : '0;
      if (rq.req_type == ReqWrite) begin
        word[0]      = rq.wdata;
        plane_ram[a] = word;
      end else begin
        res = word[0];
      end
    end else begin
      a    = rq.addr;
      word = plane_ram.exists(a) ? plane_ram[a] : '0;
      if (rq.req_type == ReqRead) begin
        for (int p = 0; p < NumPlanes; p++) latch_q[p] = word[p];
        if (cfg_shadow.graphics_mode[3]) begin
          // colour compare: a pixel matches when every included plane agrees
          colour = cfg_shadow.color_compare_ctrl[3:0];
          care   = cfg_shadow.color_compare_ctrl[7:4];
          for (int i = 0; i < ByteWidth; i++) begin
            for (int p = 0; p < NumPlanes; p++) pix[p] = latch_q[p][i];
            res[i] = (((pix ^ colour) & care) == '0);
          end
        end else begin
          res = latch_q[cfg_shadow.read_map_select];
        end
      end else begin
        mode  = wmode_e'(cfg_shadow.graphics_mode[1:0]);
        rot   = rot_right(rq.wdata, cfg_shadow.data_rotate[2:0]);
        srval = cfg_shadow.set_reset_ctrl[3:0];
        sren  = cfg_shadow.set_reset_ctrl[7:4];
        for (int p = 0; p < NumPlanes; p++) begin
          case (mode)
            WMODE_LATCH: d = latch_q[p];
            WMODE_MASKED: begin
              // set/reset value under the rotated data masked by bit_mask, no logic op
              m = rot & cfg_shadow.bit_mask;
              d = ({8{srval[p]}} & m) | (latch_q[p] & ~m);
            end
            default: begin
              if (mode == WMODE_ROTATE) d = sren[p] ? {8{srval[p]}} : rot;
              else                      d = {8{rq.wdata[p]}};
              d = apply_lop(d, latch_q[p], lop_e'(cfg_shadow.data_rotate[4:3]));
              d = (d & cfg_shadow.bit_mask) | (latch_q[p] & ~cfg_shadow.bit_mask);
            end
          endcase
          if (cfg_shadow.map_mask[p]) word[p] = d;
        end
        plane_ram[a] = word;
      end
    end
    rdata_due.push_back(res);
  endtask

  // request driver: holds a transaction until taken, then loads the next one
  always @(posedge clk or negedge rst_n) begin : req_driver
    mem_req_t nxt;
    if (!rst_n) begin
      drv_valid <= 1'b0;
    end else begin
      if (drv_valid && req_if.ready) begin
        model_access('{req_type: drv_type, addr: drv_addr, wdata: drv_wdata});
      end
      if (!drv_valid || req_if.ready) begin
        if (req_backlog.size() != 0 && !take_break()) begin
          nxt       = req_backlog.pop_front();
          drv_valid <= 1'b1;
          drv_type  <= nxt.req_type;
          drv_addr  <= nxt.addr;
          drv_wdata <= nxt.wdata;
        end else begin
          drv_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor: every transaction on rsp_o is matched against the oldest prediction
  always @(posedge clk or negedge rst_n) begin : rsp_monitor
    byte_t want;
    if (!rst_n) begin
      mon_ready <= 1'b0;
    end else begin
      if (rsp_if.valid && mon_ready) begin
        rsp_count++;
        if (rdata_due.size() == 0) begin
          note_mismatch($sformatf("response %0d rdata %02h with nothing outstanding",
                                  rsp_count, rsp_if.rdata));
        end else begin
          want = rdata_due.pop_front();
          if (rsp_if.rdata !== want)
            note_mismatch($sformatf("response %0d rdata %02h, predicted %02h",
                                    rsp_count, rsp_if.rdata, want));
        end
      end
      mon_ready <= !take_break();
    end
  end

  // register write; only called while the core is idle, returns on a falling edge
  task automatic write_reg(input logic [CfgIdxWidth-1:0] idx, input byte_t val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_SET_RESET:     cfg_shadow.set_reset_ctrl     = val;
      REG_COLOR_COMPARE: cfg_shadow.color_compare_ctrl = val;
      REG_DATA_ROTATE:   cfg_shadow.data_rotate        = val[4:0];
      REG_GRAPHICS_MODE: cfg_shadow.graphics_mode      = val[3:0];
      REG_BIT_MASK:      cfg_shadow.bit_mask           = val;
      REG_MAP_MASK:      cfg_shadow.map_mask           = val[3:0];
      REG_READ_MAP_SEL:  cfg_shadow.read_map_select    = val[1:0];
      REG_GRAPHICS_EN:   cfg_shadow.graphics_enable    = val[0];
      default: ;  // unused index, nothing changes
    endcase
    @(negedge clk);
  endtask

  // wait until every queued transaction has come back, then let the pipe settle
  task automatic drain();
    do @(negedge clk);
    while (req_backlog.size() != 0 || drv_valid || rdata_due.size() != 0);
    repeat (DrainPause) @(negedge clk);
  endtask

  function automatic bit readable(input logic [AddrWidth-1:0] addr);
    int a;
    if (cfg_shadow.graphics_enable) begin
      // a graphics read loads all four latches, so every plane must be defined
      a = int'(addr);
      return plane_fill.exists(a) && (plane_fill[a] == 4'hf);
    end
    a = int'(addr & TextMask);
    return plane_fill.exists(a) && plane_fill[a][0];
  endfunction

  // queue one transaction; written planes are tracked under the current settings
  task automatic queue_req(input logic wr, input logic [AddrWidth-1:0] addr, input byte_t wd);
    int a;
    if (wr == ReqWrite) begin
      if (cfg_shadow.graphics_enable) begin
        a = int'(addr);
        plane_fill[a] = (plane_fill.exists(a) ? plane_fill[a] : '0) | cfg_shadow.map_mask;
      end else begin
        a = int'(addr & TextMask);
        plane_fill[a] = (plane_fill.exists(a) ? plane_fill[a] : '0) | 4'b0001;
      end
    end
    req_backlog.push_back('{req_type: wr, addr: addr, wdata: wd});
    items_queued++;
  endtask

  task automatic queue_random(input int unsigned n);
    logic [AddrWidth-1:0] addr;
    int unsigned          tries;
    bit                   did_read;
    repeat (n) begin
      addr     = addr_pool[$urandom_range(addr_pool.size() - 1)];
      did_read = 1'b0;
      if ($urandom_range(99) < 45) begin
        tries = 0;
        while (!readable(addr) && tries < 8) begin
          addr = addr_pool[$urandom_range(addr_pool.size() - 1)];
          tries++;
        end
        if (readable(addr)) begin
          did_read = 1'b1;
          queue_req(ReqRead, addr, 8'($urandom_range(255)));
          // load latches then write back to the same word, the usual cpu pattern
          if ($urandom_range(99) < 40) queue_req(ReqWrite, addr, 8'($urandom_range(255)));
        end
      end
      if (!did_read) begin
        if ($urandom_range(99) < 10) addr = 16'($urandom_range(16'hffff));
        queue_req(ReqWrite, addr, 8'($urandom_range(255)));
      end
    end
  endtask

  task automatic rand_config(input int style);
    byte_t v;
    for (int i = 0; i <= REG_GRAPHICS_EN; i++) begin
      case (style)
        CfgAllZero: v = 8'h00;
        CfgAllOnes: v = 8'hff;
        default:    v = 8'($urandom_range(255));
      endcase
      // mostly planar addressing in random phases, upper bits left random
      if (i == REG_GRAPHICS_EN && style == CfgRandom) v[0] = ($urandom_range(99) < 80);
      write_reg(i[CfgIdxWidth-1:0], v);
    end
  endtask

  // directed read, write, read at one word under a full register setting
  task automatic directed_rmw(input byte_t sr, input byte_t cc, input byte_t rot,
                              input byte_t gm, input byte_t bm, input byte_t mm,
                              input byte_t rms, input logic [AddrWidth-1:0] addr,
                              input byte_t wd);
    write_reg(REG_SET_RESET, sr);
    write_reg(REG_COLOR_COMPARE, cc);
    write_reg(REG_DATA_ROTATE, rot);
    write_reg(REG_GRAPHICS_MODE, gm);
    write_reg(REG_BIT_MASK, bm);
    write_reg(REG_MAP_MASK, mm);
    write_reg(REG_READ_MAP_SEL, rms);
    queue_req(ReqRead, addr, 8'h00);
    queue_req(ReqWrite, addr, wd);
    queue_req(ReqRead, addr, 8'hff);
    drain();
  endtask

  initial begin : stimulus
    int unsigned phase;
    int          style;
    addr_pool = '{16'h0000, 16'hffff, 16'h7fff, 16'h8000};
    repeat (40) addr_pool.push_back(16'($urandom_range(16'hffff)));

    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // text addressing straight out of reset, including the aliased upper half
    queue_req(ReqWrite, 16'h0000, 8'h00);
    queue_req(ReqWrite, 16'hffff, 8'hff);
    queue_req(ReqWrite, 16'h8001, 8'h5a);
    queue_req(ReqRead, 16'h7fff, 8'h00);
    queue_req(ReqRead, 16'h8000, 8'hff);
    queue_req(ReqRead, 16'h0001, 8'h00);
    drain();

    // planar addressing; a write to an unused index must change nothing
    write_reg(REG_GRAPHICS_EN, 8'h01);
    write_reg(UnusedRegIdx, 8'h00);
    foreach (addr_pool[i]) queue_req(ReqWrite, addr_pool[i], 8'($urandom_range(255)));
    drain();

    // each write mode and logic op, both read modes, every read plane
    directed_rmw(8'h5a, 8'h00, {3'b000, LOP_XOR, 3'd3}, 8'(WMODE_ROTATE),
                 8'hf0, 8'h0f, 8'd3, 16'hffff, 8'h81);
    directed_rmw(8'h00, 8'h00, 8'h00, 8'(WMODE_LATCH),
                 8'h00, 8'h05, 8'd1, 16'h0000, 8'hff);
    directed_rmw(8'hf0, 8'h00, {3'b000, LOP_OR, 3'd0}, 8'(WMODE_EXPAND),
                 8'h3c, 8'h0a, 8'd2, 16'h7fff, 8'h06);
    directed_rmw(8'h0c, 8'h00, {3'b000, LOP_AND, 3'd7}, 8'(WMODE_MASKED),
                 8'hff, 8'h0f, 8'd0, 16'h8000, 8'ha5);
    directed_rmw(8'h00, 8'hf5, {3'b000, LOP_AND, 3'd0}, ReadCompare | 8'(WMODE_ROTATE),
                 8'h55, 8'h03, 8'd0, 16'hffff, 8'h3c);
    // compare with no plane included matches every pixel; bit 2 of the mode is unused
    directed_rmw(8'h00, 8'h0a, 8'h00, 8'h0c,
                 8'hff, 8'h0f, 8'd0, 16'h0000, 8'h99);

    // random phases with the all-zero and all-ones settings among them
    phase = 0;
    while (items_queued < ItemTarget) begin
      case (phase % 7)
        3:       style = CfgAllZero;
        5:       style = CfgAllOnes;
        default: style = CfgRandom;
      endcase
      rand_config(style);
      queue_random($urandom_range(20, 60));
      drain();
      phase++;
    end

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin : watchdog
    #(LimitNs);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
